>>> rtl/core/dfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_pkg
// shared types, codes and render tables for the display frame sequencer
// ----------------------------------------------------------------------------
package dfs_pkg;

  localparam int unsigned FramesDefault = 12;
  localparam int unsigned NumChannels   = 7;
  localparam int unsigned WordsPerFrame = 6;
  localparam int unsigned ImageBytes    = 33;
  localparam int unsigned ImgAw         = 6;

  localparam logic [7:0] ADDR_CMD = 8'hC0;

  typedef enum logic [2:0] {
    CMD_HDR  = 3'd0,
    CMD_DATA = 3'd1,
    CMD_ARM  = 3'd2,
    CMD_TICK = 3'd3,
    CMD_HEAD = 3'd4
  } cmd_e;

  localparam logic [2:0] CH_ICONS = 3'd0;
  localparam logic [2:0] CH_STAR  = 3'd1;
  localparam logic [2:0] CH_DIGIT = 3'd2;
  localparam logic [2:0] CH_RING  = 3'd3;
  localparam logic [2:0] CH_GRID  = 3'd4;
  localparam logic [2:0] CH_DISC  = 3'd5;
  localparam logic [2:0] CH_LAST  = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_DEC,
    ST_FETCH,
    ST_WRITE,
    ST_ADDR,
    ST_RD,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic [7:0]  dur;
    logic [3:0]  link;
    logic [15:0] ov;
  } hdr_t;

  localparam logic [5:0] ICON_ADDR [10] = '{6'd20, 6'd23, 6'd17, 6'd32, 6'd11,
                                            6'd14, 6'd8, 6'd5, 6'd2, 6'd29};
  localparam logic [5:0] STAR_ADDR [5]  = '{6'd12, 6'd9, 6'd6, 6'd3, 6'd0};
  localparam logic [5:0] DIGIT_ADDR [6] = '{6'd15, 6'd21, 6'd22, 6'd18, 6'd19, 6'd16};

  function automatic logic [3:0] rnd_count(input logic [2:0] ch);
    logic [3:0] n;
    unique case (ch)
      CH_ICONS: n = 4'd10;
      CH_STAR:  n = 4'd10;
      CH_DIGIT: n = 4'd6;
      CH_RING:  n = 4'd2;
      CH_GRID:  n = 4'd2;
      default:  n = 4'd1;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] rnd_word(input logic [2:0] ch, input logic [3:0] step);
    logic [2:0] k;
    unique case (ch)
      CH_STAR:  k = step[3:1];
      CH_DIGIT: k = step[2:0];
      default:  k = 3'd0;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] rnd_addr(input logic [2:0] ch, input logic [3:0] step);
    logic [5:0] a;
    unique case (ch)
      CH_ICONS: a = ICON_ADDR[step];
      CH_STAR:  a = STAR_ADDR[step[3:1]] + {5'd0, step[0]};
      CH_DIGIT: a = DIGIT_ADDR[step[2:0]];
      CH_RING:  a = step[0] ? 6'd31 : 6'd30;
      CH_GRID:  a = step[0] ? 6'd28 : 6'd27;
      CH_DISC:  a = 6'd24;
      default:  a = 6'd25;
    endcase
    return a;
  endfunction

  function automatic logic [7:0] rnd_byte(input logic [2:0] ch, input logic [3:0] step,
                                          input logic [15:0] w, input logic [15:0] ov);
    logic [7:0]  b;
    logic [15:0] v;
    v = w | ov;
    unique case (ch)
      CH_ICONS: b = {7'd0, w[step]};
      CH_STAR:  b = step[0] ? w[7:0] : w[15:8];
      CH_DIGIT: b = (step == 4'd0) ? w[7:0] : {w[7] | ov[4'(step - 4'd1)], w[6:0]};
      CH_RING:  b = step[0] ? v[15:8] : v[7:0];
      CH_GRID:  b = step[0] ? w[15:8] : w[7:0];
      CH_DISC:  b = w[7:0];
      default:  b = v[7:0];
    endcase
    return b;
  endfunction

endpackage

>>> rtl/core/dfs_frame_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_frame_store
// frame header and data word memories with a clearing pass after reset
// ----------------------------------------------------------------------------
module dfs_frame_store import dfs_pkg::*; #(
  parameter int unsigned FRAMES_PER_CHANNEL = FramesDefault,
  localparam int unsigned NHdr  = NumChannels * FRAMES_PER_CHANNEL,
  localparam int unsigned NWrd  = NHdr * WordsPerFrame,
  localparam int unsigned HdrAw = $clog2(NHdr),
  localparam int unsigned WrdAw = $clog2(NWrd),
  localparam int unsigned ClrW  = $clog2(NWrd + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  output logic             busy_o,
  input  logic             hdr_we_i,
  input  logic [HdrAw-1:0] hdr_waddr_i,
  input  hdr_t             hdr_wdata_i,
  input  logic [HdrAw-1:0] hdr_raddr_i,
  output hdr_t             hdr_rdata_o,
  input  logic             wrd_we_i,
  input  logic [WrdAw-1:0] wrd_waddr_i,
  input  logic [15:0]      wrd_wdata_i,
  input  logic [WrdAw-1:0] wrd_raddr_i,
  output logic [15:0]      wrd_rdata_o
);

  hdr_t        hdr_mem [NHdr];
  logic [15:0] wrd_mem [NWrd];
  logic [ClrW-1:0] clr_q, clr_d;

  assign busy_o = (clr_q != ClrW'(NWrd));
  assign clr_d  = busy_o ? clr_q + 1'b1 : clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_o) begin
      wrd_mem[clr_q[WrdAw-1:0]] <= '0;
      if (clr_q < ClrW'(NHdr)) begin
        hdr_mem[clr_q[HdrAw-1:0]] <= '0;
      end
    end else begin
      if (hdr_we_i) begin
        hdr_mem[hdr_waddr_i] <= hdr_wdata_i;
      end
      if (wrd_we_i) begin
        wrd_mem[wrd_waddr_i] <= wrd_wdata_i;
      end
    end
    hdr_rdata_o <= hdr_mem[hdr_raddr_i];
    wrd_rdata_o <= wrd_mem[wrd_raddr_i];
  end

endmodule

>>> rtl/core/dfs_image_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_image_ram
// display memory image, per-byte valid bits so reset reads as zero
// ----------------------------------------------------------------------------
module dfs_image_ram import dfs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [ImgAw-1:0]  waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic [ImgAw-1:0]  raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0]            mem [ImageBytes];
  logic [ImageBytes-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= vld_q[raddr_i] ? mem[raddr_i] : 8'd0;
  end

endmodule

>>> rtl/core/display_frame_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_frame_sequencer
// animation frame player for seven display channels with display image output
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid_i/in_stall_o | command, channel, entry, word_index,
//          |                      | duration, next_entry, data_word, overlay_word
//  out     | out_valid_o/out_stall_i | kind, out_byte, last, head_report
//
//  writes, arm and head reads are handled in the idle state; a tick steps
//  through each channel (header read, decode) and each rendered image byte
//  (fetch, write), then emits an address word and each image byte (read, load)
//  after reset a clearing pass over the frame stores runs first
//  a stalled output word holds the sequencer at its emit step
// ----------------------------------------------------------------------------
module display_frame_sequencer import dfs_pkg::*; #(
  parameter int unsigned FRAMES_PER_CHANNEL = FramesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [2:0]  channel_i,
  input  logic [3:0]  entry_i,
  input  logic [2:0]  word_index_i,
  input  logic [7:0]  duration_i,
  input  logic [3:0]  next_entry_i,
  input  logic [15:0] data_word_i,
  input  logic [15:0] overlay_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic [3:0]  head_report_o
);

  localparam int unsigned NHdr  = NumChannels * FRAMES_PER_CHANNEL;
  localparam int unsigned NWrd  = NHdr * WordsPerFrame;
  localparam int unsigned HdrAw = $clog2(NHdr);
  localparam int unsigned WrdAw = $clog2(NWrd);

  state_e state_q, state_d;
  logic [2:0] ch_q, ch_d;
  logic [3:0] step_q, step_d;
  logic [5:0] k_q, k_d;
  logic       any_q, any_d;
  logic [HdrAw-1:0] slot_q, slot_d;
  logic [15:0] ov_q, ov_d;
  logic [3:0] head_q [NumChannels];
  logic [3:0] head_d [NumChannels];
  logic [7:0] timer_q [NumChannels];
  logic [7:0] timer_d [NumChannels];
  logic [NumChannels-1:0] armed_q, armed_d;

  logic       ov_valid_q, ov_valid_d;
  logic       kind_q, kind_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic [3:0] hrep_q, hrep_d;

  logic             busy;
  logic             hdr_we, wrd_we, img_we;
  logic [HdrAw-1:0] in_slot, hdr_raddr;
  logic [WrdAw-1:0] wrd_waddr, wrd_raddr;
  hdr_t             hdr_wdata, hdr_rdata;
  logic [15:0]      wrd_rdata;
  logic [ImgAw-1:0] img_waddr, img_raddr;
  logic [7:0]       img_wdata, img_rdata;
  logic ch_ok, ent_ok, accept, out_free, next_any;

  assign ch_ok     = (channel_i < 3'(NumChannels));
  assign ent_ok    = (32'(entry_i) < FRAMES_PER_CHANNEL);
  assign in_slot   = HdrAw'(32'(channel_i) * FRAMES_PER_CHANNEL + 32'(entry_i));
  assign wrd_waddr = WrdAw'(32'(in_slot) * WordsPerFrame + 32'(word_index_i));
  assign hdr_wdata.dur  = duration_i;
  assign hdr_wdata.link = (32'(next_entry_i) < FRAMES_PER_CHANNEL) ? next_entry_i : 4'd0;
  assign hdr_wdata.ov   = overlay_word_i;
  assign hdr_raddr = HdrAw'(32'(ch_q) * FRAMES_PER_CHANNEL + 32'(head_q[ch_q]));
  assign wrd_raddr = WrdAw'(32'(slot_q) * WordsPerFrame + 32'(rnd_word(ch_q, step_q)));
  assign img_waddr = rnd_addr(ch_q, step_q);
  assign img_wdata = rnd_byte(ch_q, step_q, wrd_rdata, ov_q);
  assign img_raddr = k_q - 6'd1;

  assign out_free   = !ov_valid_q || !out_stall_i;
  assign in_stall_o = !(state_q == ST_IDLE && !busy && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ch_q       <= '0;
      step_q     <= '0;
      k_q        <= '0;
      any_q      <= 1'b0;
      armed_q    <= '0;
      ov_valid_q <= 1'b0;
      for (int i = 0; i < NumChannels; i++) begin
        head_q[i]  <= '0;
        timer_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      ch_q       <= ch_d;
      step_q     <= step_d;
      k_q        <= k_d;
      any_q      <= any_d;
      armed_q    <= armed_d;
      ov_valid_q <= ov_valid_d;
      head_q     <= head_d;
      timer_q    <= timer_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    ov_q   <= ov_d;
    kind_q <= kind_d;
    byte_q <= byte_d;
    last_q <= last_d;
    hrep_q <= hrep_d;
  end

  always_comb begin
    state_d    = state_q;
    ch_d       = ch_q;
    step_d     = step_q;
    k_d        = k_q;
    any_d      = any_q;
    slot_d     = slot_q;
    ov_d       = ov_q;
    head_d     = head_q;
    timer_d    = timer_q;
    armed_d    = armed_q;
    ov_valid_d = ov_valid_q && out_stall_i;
    kind_d     = kind_q;
    byte_d     = byte_q;
    last_d     = last_q;
    hrep_d     = hrep_q;
    hdr_we     = 1'b0;
    wrd_we     = 1'b0;
    img_we     = 1'b0;
    next_any   = any_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (command_i)
            CMD_HDR:  hdr_we = ch_ok && ent_ok;
            CMD_DATA: wrd_we = ch_ok && ent_ok && (word_index_i < 3'(WordsPerFrame));
            CMD_ARM: begin
              if (ch_ok) begin
                armed_d[channel_i] = 1'b1;
              end
            end
            CMD_TICK: begin
              ch_d    = '0;
              any_d   = 1'b0;
              state_d = ST_HDR;
            end
            CMD_HEAD: begin
              ov_valid_d = 1'b1;
              kind_d     = 1'b1;
              byte_d     = 8'd0;
              last_d     = 1'b1;
              hrep_d     = ch_ok ? head_q[channel_i] : 4'd0;
            end
            default: ;
          endcase
        end
      end
      ST_HDR: begin
        slot_d  = hdr_raddr;
        state_d = ST_DEC;
      end
      ST_DEC: begin
        if (armed_q[ch_q]) begin
          armed_d[ch_q] = 1'b0;
          timer_d[ch_q] = hdr_rdata.dur + 8'hFF;
          ov_d          = hdr_rdata.ov;
          any_d         = 1'b1;
          step_d        = '0;
          state_d       = ST_FETCH;
        end else begin
          if (timer_q[ch_q] > 8'd1) begin
            timer_d[ch_q] = timer_q[ch_q] - 8'd1;
          end else begin
            head_d[ch_q]  = hdr_rdata.link;
            armed_d[ch_q] = 1'b1;
          end
          if (ch_q == CH_LAST) begin
            k_d     = '0;
            state_d = next_any ? ST_ADDR : ST_IDLE;
          end else begin
            ch_d    = ch_q + 3'd1;
            state_d = ST_HDR;
          end
        end
      end
      ST_FETCH: state_d = ST_WRITE;
      ST_WRITE: begin
        img_we = 1'b1;
        step_d = step_q + 4'd1;
        if (step_d == rnd_count(ch_q)) begin
          if (ch_q == CH_LAST) begin
            k_d     = '0;
            state_d = ST_ADDR;
          end else begin
            ch_d    = ch_q + 3'd1;
            state_d = ST_HDR;
          end
        end else begin
          state_d = ST_FETCH;
        end
      end
      ST_ADDR: begin
        if (out_free) begin
          ov_valid_d = 1'b1;
          kind_d     = 1'b0;
          byte_d     = ADDR_CMD;
          last_d     = 1'b0;
          hrep_d     = 4'd0;
          k_d        = 6'd1;
          state_d    = ST_RD;
        end
      end
      ST_RD: state_d = ST_LOAD;
      ST_LOAD: begin
        if (out_free) begin
          ov_valid_d = 1'b1;
          kind_d     = 1'b0;
          byte_d     = img_rdata;
          last_d     = (k_q == 6'(ImageBytes));
          hrep_d     = 4'd0;
          if (k_q == 6'(ImageBytes)) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + 6'd1;
            state_d = ST_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  dfs_frame_store #(
    .FRAMES_PER_CHANNEL (FRAMES_PER_CHANNEL)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .busy_o      (busy),
    .hdr_we_i    (hdr_we),
    .hdr_waddr_i (in_slot),
    .hdr_wdata_i (hdr_wdata),
    .hdr_raddr_i (hdr_raddr),
    .hdr_rdata_o (hdr_rdata),
    .wrd_we_i    (wrd_we),
    .wrd_waddr_i (wrd_waddr),
    .wrd_wdata_i (data_word_i),
    .wrd_raddr_i (wrd_raddr),
    .wrd_rdata_o (wrd_rdata)
  );

  dfs_image_ram u_image (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (img_we),
    .waddr_i (img_waddr),
    .wdata_i (img_wdata),
    .raddr_i (img_raddr),
    .rdata_o (img_rdata)
  );

  assign out_valid_o   = ov_valid_q;
  assign kind_o        = kind_q;
  assign out_byte_o    = byte_q;
  assign last_o        = last_q;
  assign head_report_o = hrep_q;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the display frame sequencer
// ----------------------------------------------------------------------------
// A driver feeds commands from a queue of pending words and a monitor checks
// every output word against a behavioural copy of the frame stores, head
// pointers, hold timers and display image kept inside the bench. A short
// directed run covers the edge cases and every command. A random run follows,
// made mostly of header writes, data writes, arms and ticks, so that
// animations play and images are emitted. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import dfs_pkg::*;

  localparam int unsigned Frames     = 12;
  localparam int unsigned RandItems  = 280;
  localparam int unsigned CycleLimit = 1000000;
  localparam logic [2:0]  CmdSpareLo = 3'd5;
  localparam logic [2:0]  CmdSpareHi = 3'd7;
  localparam logic [2:0]  ChBad      = 3'd7;

  typedef struct {
    logic [2:0]  cmd;
    logic [2:0]  ch;
    logic [3:0]  ent;
    logic [2:0]  wi;
    logic [7:0]  dur;
    logic [3:0]  nxt;
    logic [15:0] dw;
    logic [15:0] ov;
    bit          drain;
  } cmd_word_t;

  typedef struct {
    logic       kind;
    logic [7:0] val;
    logic       last;
    logic [3:0] head;
  } out_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  command_i = '0;
  logic [2:0]  channel_i = '0;
  logic [3:0]  entry_i = '0;
  logic [2:0]  word_index_i = '0;
  logic [7:0]  duration_i = '0;
  logic [3:0]  next_entry_i = '0;
  logic [15:0] data_word_i = '0;
  logic [15:0] overlay_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        kind_o;
  logic [7:0]  out_byte_o;
  logic        last_o;
  logic [3:0]  head_report_o;

  display_frame_sequencer #(.FRAMES_PER_CHANNEL(Frames)) i_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // behavioural copy of the block state
  logic [7:0]  frame_dur  [NumChannels][Frames];
  logic [3:0]  frame_link [NumChannels][Frames];
  logic [15:0] frame_data [NumChannels][Frames][WordsPerFrame];
  logic [15:0] frame_ovl  [NumChannels][Frames];
  logic [3:0]  head_ptr   [NumChannels];
  logic [7:0]  hold_cnt   [NumChannels];
  bit          armed      [NumChannels];
  logic [7:0]  image      [ImageBytes];

  cmd_word_t pending_cmds[$];
  out_word_t expected_words[$];
  int unsigned errors, words_seen, cmds_taken, images_seen, cycles;

  const logic [5:0] icon_pos  [10] = '{20, 23, 17, 32, 11, 14, 8, 5, 2, 29};
  const logic [5:0] star_pos  [5]  = '{12, 9, 6, 3, 0};
  const logic [5:0] digit_pos [6]  = '{15, 21, 22, 18, 19, 16};

  task automatic draw_frame(input int c, input int e);
    logic [15:0] v;
    v = frame_data[c][e][0] | frame_ovl[c][e];
    case (c)
      CH_ICONS: begin
        for (int k = 0; k < 10; k++) image[icon_pos[k]] = {7'd0, frame_data[c][e][0][k]};
      end
      CH_STAR: begin
        for (int k = 0; k < 5; k++) begin
          image[star_pos[k]]     = frame_data[c][e][k][15:8];
          image[star_pos[k] + 1] = frame_data[c][e][k][7:0];
        end
      end
      CH_DIGIT: begin
        for (int k = 0; k < 6; k++) begin
          image[digit_pos[k]] = frame_data[c][e][k][7:0];
          if (k > 0) image[digit_pos[k]][7] = image[digit_pos[k]][7] | frame_ovl[c][e][k-1];
        end
      end
      CH_RING: begin
        image[30] = v[7:0];
        image[31] = v[15:8];
      end
      CH_GRID: begin
        image[27] = frame_data[c][e][0][7:0];
        image[28] = frame_data[c][e][0][15:8];
      end
      CH_DISC: image[24] = frame_data[c][e][0][7:0];
      default: image[25] = v[7:0];
    endcase
  endtask

  task automatic sequence_command(input cmd_word_t w);
    bit ch_ok, ent_ok, shown;
    ch_ok  = w.ch < NumChannels;
    ent_ok = w.ent < Frames;
    shown  = 1'b0;
    case (w.cmd)
      CMD_HDR: if (ch_ok && ent_ok) begin
        frame_dur[w.ch][w.ent]  = w.dur;
        frame_link[w.ch][w.ent] = (w.nxt < Frames) ? w.nxt : 4'd0;
        frame_ovl[w.ch][w.ent]  = w.ov;
      end
      CMD_DATA: if (ch_ok && ent_ok && w.wi < WordsPerFrame) frame_data[w.ch][w.ent][w.wi] = w.dw;
      CMD_ARM: if (ch_ok) armed[w.ch] = 1'b1;
      CMD_TICK: begin
        for (int c = 0; c < NumChannels; c++) begin
          if (armed[c]) begin
            armed[c] = 1'b0;
            hold_cnt[c] = frame_dur[c][head_ptr[c]] - 8'd1;
            draw_frame(c, head_ptr[c]);
            shown = 1'b1;
          end else if (hold_cnt[c] > 8'd1) begin
            hold_cnt[c] = hold_cnt[c] - 8'd1;
          end else begin
            head_ptr[c] = frame_link[c][head_ptr[c]];
            armed[c] = 1'b1;
          end
        end
        if (shown) begin
          images_seen++;
          expected_words.push_back('{1'b0, ADDR_CMD, 1'b0, 4'd0});
          for (int k = 0; k < ImageBytes; k++)
            expected_words.push_back('{1'b0, image[k], k == ImageBytes - 1, 4'd0});
        end
      end
      CMD_HEAD: expected_words.push_back('{1'b1, 8'd0, 1'b1, ch_ok ? head_ptr[w.ch] : 4'd0});
      default: ;
    endcase
  endtask

  task automatic queue_cmd(input logic [2:0] cmd, input logic [2:0] ch, input logic [3:0] ent,
                           input logic [2:0] wi, input logic [7:0] dur, input logic [3:0] nxt,
                           input logic [15:0] dw, input logic [15:0] ov);
    pending_cmds.push_back('{cmd, ch, ent, wi, dur, nxt, dw, ov, 1'b0});
  endtask

  function automatic cmd_word_t random_cmd();
    cmd_word_t w;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) w.cmd = CMD_HDR;
    else if (r < 45) w.cmd = CMD_DATA;
    else if (r < 57) w.cmd = CMD_ARM;
    else if (r < 87) w.cmd = CMD_TICK;
    else if (r < 96) w.cmd = CMD_HEAD;
    else w.cmd = 3'($urandom_range(CmdSpareLo, CmdSpareHi));
    w.ch  = ($urandom_range(19) == 0) ? ChBad : 3'($urandom_range(NumChannels - 1));
    w.ent = ($urandom_range(14) == 0) ? 4'($urandom_range(Frames, 15)) : 4'($urandom_range(3));
    w.wi  = ($urandom_range(9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(5));
    r = $urandom_range(29);
    w.dur = (r == 0) ? 8'($urandom_range(255)) : (r == 1) ? 8'd0 : 8'($urandom_range(1, 4));
    w.nxt = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
    w.dw  = 16'($urandom());
    w.ov  = 16'($urandom());
    w.drain = 1'b0;
    return w;
  endfunction

  // driver
  int unsigned burst_left, gap_left;
  cmd_word_t cur_cmd;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        sequence_command(cur_cmd);
        cmds_taken++;
      end
      if (in_valid_i && in_stall_o) begin
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (pending_cmds[0].drain) begin
        in_valid_i <= 1'b0;
        if (expected_words.size() == 0) void'(pending_cmds.pop_front());
      end else begin
        cur_cmd = pending_cmds.pop_front();
        in_valid_i     <= 1'b1;
        command_i      <= cur_cmd.cmd;
        channel_i      <= cur_cmd.ch;
        entry_i        <= cur_cmd.ent;
        word_index_i   <= cur_cmd.wi;
        duration_i     <= cur_cmd.dur;
        next_entry_i   <= cur_cmd.nxt;
        data_word_i    <= cur_cmd.dw;
        overlay_word_i <= cur_cmd.ov;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // monitor and receiver stall
  int unsigned stall_phase, phase_left, long_hold;
  bit long_hold_done;
  out_word_t exp_w;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i    <= 1'b0;
      phase_left     <= 0;
      long_hold      <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          $error("unexpected output word: byte %0h kind %0b", out_byte_o, kind_o);
          errors++;
        end else begin
          exp_w = expected_words.pop_front();
          if (kind_o !== exp_w.kind) begin
            $error("kind: expected %0h actual %0h", exp_w.kind, kind_o);
            errors++;
          end
          if (out_byte_o !== exp_w.val) begin
            $error("out_byte: expected %0h actual %0h", exp_w.val, out_byte_o);
            errors++;
          end
          if (last_o !== exp_w.last) begin
            $error("last: expected %0h actual %0h", exp_w.last, last_o);
            errors++;
          end
          if (head_report_o !== exp_w.head) begin
            $error("head_report: expected %0h actual %0h", exp_w.head, head_report_o);
            errors++;
          end
        end
      end
      if (long_hold > 0) begin
        long_hold <= long_hold - 1;
        out_stall_i <= long_hold > 1;
      end else if (!long_hold_done && words_seen >= 200 && out_valid_o) begin
        long_hold_done <= 1'b1;
        long_hold <= 600;
        out_stall_i <= 1'b1;
      end else begin
        if (phase_left == 0) begin
          stall_phase <= $urandom_range(2);
          phase_left  <= $urandom_range(8, 80);
        end else begin
          phase_left <= phase_left - 1;
        end
        case (stall_phase)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= $urandom_range(3) == 0;
          default: out_stall_i <= $urandom_range(3) != 0;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    cmd_word_t w;
    for (int c = 0; c < NumChannels; c++) begin
      head_ptr[c] = '0;
      hold_cnt[c] = '0;
      armed[c] = 1'b0;
      for (int e = 0; e < Frames; e++) begin
        frame_dur[c][e] = '0;
        frame_link[c][e] = '0;
        frame_ovl[c][e] = '0;
        for (int k = 0; k < WordsPerFrame; k++) frame_data[c][e][k] = '0;
      end
    end
    foreach (image[k]) image[k] = '0;

    // directed: extremes, every command, ignored writes, stored link clamp
    queue_cmd(CMD_TICK, CH_ICONS, 0, 0, 0, 0, 0, 0);
    queue_cmd(CMD_HEAD, ChBad, 0, 0, 0, 0, 0, 0);
    queue_cmd(CMD_HDR, CH_DIGIT, 0, 0, 8'hFF, 4'd15, 0, 16'hFFFF);
    queue_cmd(CMD_HDR, CH_RING, 4'd11, 0, 8'd1, 4'd11, 0, 16'h8001);
    queue_cmd(CMD_HDR, CH_ICONS, 4'd15, 0, 8'd3, 4'd2, 0, 16'hFFFF);
    queue_cmd(CMD_HDR, ChBad, 0, 0, 8'd3, 4'd2, 0, 16'hFFFF);
    queue_cmd(CMD_DATA, CH_STAR, 0, 3'd4, 0, 0, 16'hFFFF, 0);
    queue_cmd(CMD_DATA, CH_DIGIT, 0, 3'd5, 0, 0, 16'h00FF, 0);
    queue_cmd(CMD_DATA, CH_DIGIT, 0, 3'd7, 0, 0, 16'hAAAA, 0);
    queue_cmd(CMD_DATA, CH_ICONS, 4'd12, 0, 0, 0, 16'hFFFF, 0);
    queue_cmd(CMD_DATA, CH_ICONS, 0, 0, 0, 0, 16'h03FF, 0);
    queue_cmd(CMD_DATA, CH_LAST, 0, 0, 0, 0, 16'h5500, 0);
    queue_cmd(CMD_HDR, CH_LAST, 0, 0, 8'd2, 0, 0, 16'h00AA);
    queue_cmd(CMD_ARM, ChBad, 0, 0, 0, 0, 0, 0);
    for (int c = 0; c < NumChannels; c++) queue_cmd(CMD_ARM, 3'(c), 0, 0, 0, 0, 0, 0);
    queue_cmd(CmdSpareLo, CH_ICONS, 0, 0, 0, 0, 0, 0);
    queue_cmd(CmdSpareHi, CH_ICONS, 0, 0, 0, 0, 0, 0);
    queue_cmd(CMD_TICK, CH_ICONS, 0, 0, 0, 0, 0, 0);
    queue_cmd(CMD_TICK, CH_ICONS, 0, 0, 0, 0, 0, 0);
    queue_cmd(CMD_HEAD, CH_DIGIT, 0, 0, 0, 0, 0, 0);

    for (int i = 0; i < RandItems; i++) begin
      if (i == RandItems / 2) begin
        w.drain = 1'b1;
        pending_cmds.push_back(w);
      end
      pending_cmds.push_back(random_cmd());
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_cmds.size() == 0 && !in_valid_i);
    wait (expected_words.size() == 0);
    repeat (300) @(posedge clk_i);

    $display("run: %0d commands taken, %0d images and %0d output words checked",
             cmds_taken, images_seen, words_seen);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
